// ===== src/persistent_trie_range_max_xor_macros.svh =====
// ----------------------------------------------------------------------------
// persistent_trie_range_max_xor_macros
// assertion macros for the range max-xor trie
// ----------------------------------------------------------------------------
`ifndef PERSISTENT_TRIE_RANGE_MAX_XOR_MACROS_SVH
`define PERSISTENT_TRIE_RANGE_MAX_XOR_MACROS_SVH
// implication checked on every edge outside reset
`define PTRX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define PTRX_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/ptrx_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrx_pkg
// shared constants of the range max-xor trie
// ----------------------------------------------------------------------------
package ptrx_pkg;
  localparam int ValueBitsDef   = 32;
  localparam int MaxVersionsDef = 1024;
  localparam int NodeSlotsDef   = 65536;
  localparam int BoundW         = 11;

  localparam logic [1:0] StAppended = 2'd0;
  localparam logic [1:0] StAnswered = 2'd1;
  localparam logic [1:0] StBadBound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic OpAppend = 1'b0;
  localparam logic OpQuery  = 1'b1;
endpackage

// ===== src/persistent_trie_range_max_xor.sv =====
// ----------------------------------------------------------------------------
// persistent_trie_range_max_xor
// persistent binary trie answering range maximum-xor queries
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// s_axis  | in  | tvalid/tready       | tuser op, tdata value,range_low,range_high
// m_axis  | out | tvalid/tready       | tdata max_xor,status
// one item at a time: the request is taken, the token walks the chain of
// level cells, one level per cycle, then the result waits in the output
// register. Errors skip the walk and go straight to the output register.
// The first cycle after reset writes the version 0 node into every level
// and holds the request side off. A stalled output holds the result; the
// next request is taken once it is collected.
module persistent_trie_range_max_xor import ptrx_pkg::*; #(
  parameter int VALUE_BITS   = ValueBitsDef,
  parameter int MAX_VERSIONS = MaxVersionsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic        s_axis_tuser,  // op
  input  logic [55:0] s_axis_tdata,  // value[31:0], range_low[42:32], range_high[53:43]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // max_xor[31:0], status[33:32]
);
`include "persistent_trie_range_max_xor_macros.svh"
  localparam int VerW = BoundW;
  localparam int IdxW = $clog2(MAX_VERSIONS + 2);

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SWalk = 2'd1;
  localparam logic [1:0] SOut  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic                  init_q;
  logic [VALUE_BITS-1:0] pfx_q, key_q, best_q;
  logic [VerW-1:0]       cnt_ver_q, floor_q;
  logic [IdxW-1:0]       new_q;
  logic                  app_q;
  logic [1:0]            st_q;

  logic [31:0]           in_val;
  logic [VerW-1:0]       lo, hi;
  logic [VALUE_BITS-1:0] in_key;
  logic                  is_app, accept, bad, full, start, take_any;

  // per-level tokens; level i is bit VALUE_BITS-1-i
  logic            vld  [VALUE_BITS+1];
  logic            take [VALUE_BITS];
  logic [IdxW-1:0] cur  [VALUE_BITS+1];
  logic [IdxW-1:0] old  [VALUE_BITS+1];

  assign in_val = s_axis_tdata[31:0];
  assign lo     = s_axis_tdata[42:32];
  assign hi     = s_axis_tdata[53:43];
  assign is_app = (s_axis_tuser == OpAppend);
  assign in_key = pfx_q ^ in_val[VALUE_BITS-1:0];

  // request checks
  assign s_axis_tready = (state_q == SIdle) && !init_q;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign bad  = (lo == '0) || (lo > hi) || ({1'b0, hi} > {1'b0, cnt_ver_q} + 12'd1);
  assign full = ({21'd0, cnt_ver_q} >= 32'(MAX_VERSIONS));
  assign start = accept && (is_app ? !full : !bad);

  // version v owns node v + 1 in every level
  assign vld[0] = start;
  assign cur[0] = is_app ? '0 : IdxW'(hi);
  assign old[0] = IdxW'(cnt_ver_q + 11'd1);

  // request fields held for the walk
  always_ff @(posedge clk_i) begin
    if (accept) begin
      app_q   <= is_app;
      key_q   <= in_key;
      floor_q <= lo - 1'b1;
      new_q   <= IdxW'(cnt_ver_q + 11'd2);
      st_q    <= is_app ? (full ? StFull : StAppended)
                        : (bad ? StBadBound : StAnswered);
    end
  end

  // chain of level cells
  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_lvl
    ptrx_level #(.VerW(VerW), .IdxW(IdxW)) u_lvl (
      .clk_i, .rst_ni,
      .init_i(init_q), .app_i(app_q), .bit_i(key_q[VALUE_BITS-1-i]),
      .new_i(new_q), .floor_i(floor_q),
      .tok_vld_i(vld[i]), .tok_cur_i(cur[i]), .tok_old_i(old[i]),
      .tok_vld_o(vld[i+1]), .tok_take_o(take[i]),
      .tok_cur_o(cur[i+1]), .tok_old_o(old[i+1])
    );
  end

  // bit chosen by the level holding the token
  always_comb begin
    take_any = 1'b0;
    for (int i = 0; i < VALUE_BITS; i++) take_any = take_any | take[i];
  end

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (accept) state_d = start ? SWalk : SOut;
      SWalk: if (vld[VALUE_BITS]) state_d = SOut;
      SOut:  if (m_axis_tready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      init_q    <= 1'b1;
      pfx_q     <= '0;
      cnt_ver_q <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= 1'b0;
      if (start && is_app) begin
        pfx_q     <= in_key;
        cnt_ver_q <= cnt_ver_q + 1'b1;
      end
    end
  end

  // result assembly: each level adds one bit of the chosen path
  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_q <= '0;
    end else if (state_q == SWalk) begin
      best_q <= {best_q[VALUE_BITS-2:0], take_any};
    end
  end

  assign m_axis_tvalid = (state_q == SOut);
  assign m_axis_tdata  = {6'd0, st_q, 32'(best_q)};

  `PTRX_ASSERT_IMP(a_ready_idle, s_axis_tready, !m_axis_tvalid, "ready while result pending")
  `PTRX_ASSERT_NXT(a_ver_grow, start && is_app,
    cnt_ver_q == $past(cnt_ver_q) + 1'b1, "version count did not advance")
  `PTRX_ASSERT_IMP(a_ver_cap, 1'b1, {21'd0, cnt_ver_q} <= 32'(MAX_VERSIONS),
    "version count past cap")
endmodule

// ===== src/ptrx_level.sv =====
// ----------------------------------------------------------------------------
// ptrx_level
// one trie level: holds the nodes of that depth and hands the walk down
// ----------------------------------------------------------------------------
// Nodes of a level are numbered locally: version v creates exactly one node
// per level, numbered v + 1, so a node number also gives the newest version
// through it. Children of a level's node are node numbers of the next level.
// Node 0 is null. The links of the nodes a token needs are read into
// registers as the token arrives; the token is handed on in the next cycle.
module ptrx_level import ptrx_pkg::*; #(
  parameter int VerW = 11,
  parameter int IdxW = 11
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            init_i,
  // fields of the request in flight, held for the whole walk
  input  logic            app_i,
  input  logic            bit_i,
  input  logic [IdxW-1:0] new_i,
  input  logic [VerW-1:0] floor_i,
  // walk token arriving from the level above
  input  logic            tok_vld_i,
  input  logic [IdxW-1:0] tok_cur_i,
  input  logic [IdxW-1:0] tok_old_i,
  output logic            tok_vld_o,
  output logic            tok_take_o,
  output logic [IdxW-1:0] tok_cur_o,
  output logic [IdxW-1:0] tok_old_o
);
  localparam int Depth = 2 ** IdxW;
  localparam int CmpW  = (IdxW > VerW) ? IdxW : VerW;
  localparam logic [IdxW-1:0] VerZeroNode = IdxW'(1);

  logic [IdxW-1:0] link0_mem [Depth];
  logic [IdxW-1:0] link1_mem [Depth];
  logic            vld_q;
  logic            cur_nul_q, old_nul_q;
  logic [IdxW-1:0] c0_q, c1_q, o0_q, o1_q;
  logic [IdxW-1:0] c0, c1, o0, o1, alt;
  logic            alt_ok;

  // token presence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_vld_i;
    end
  end

  // registered reads of the current and the old node
  always_ff @(posedge clk_i) begin
    if (tok_vld_i) begin
      cur_nul_q <= (tok_cur_i == '0);
      old_nul_q <= (tok_old_i == '0);
      c0_q      <= link0_mem[tok_cur_i];
      c1_q      <= link1_mem[tok_cur_i];
      o0_q      <= link0_mem[tok_old_i];
      o1_q      <= link1_mem[tok_old_i];
    end
  end

  // null node has no children; sibling must hold a version at or above floor
  always_comb begin
    c0     = cur_nul_q ? '0 : c0_q;
    c1     = cur_nul_q ? '0 : c1_q;
    o0     = old_nul_q ? '0 : o0_q;
    o1     = old_nul_q ? '0 : o1_q;
    alt    = bit_i ? c0 : c1;
    alt_ok = (alt != '0) && (CmpW'(alt) > CmpW'(floor_i));
  end

  // version 0 node after reset, then path copy keeping the old sibling
  always_ff @(posedge clk_i) begin
    if (init_i) begin
      link0_mem[VerZeroNode] <= VerZeroNode;
      link1_mem[VerZeroNode] <= '0;
    end else if (vld_q && app_i) begin
      link0_mem[new_i] <= bit_i ? o0 : new_i;
      link1_mem[new_i] <= bit_i ? new_i : o1;
    end
  end

  // hand the token to the next level
  assign tok_vld_o  = vld_q;
  assign tok_take_o = vld_q && !app_i && alt_ok;
  assign tok_cur_o  = (app_i || !alt_ok) ? (bit_i ? c1 : c0) : alt;
  assign tok_old_o  = bit_i ? o1 : o0;
endmodule
